>>> design/closest_point_of_approach_top_assert.svh
// Assertion macros for the closest point of approach block.
`ifndef CLOSEST_POINT_OF_APPROACH_TOP_ASSERT_SVH
`define CLOSEST_POINT_OF_APPROACH_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define CPA_ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define CPA_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define CPA_ASSERT_CLK(lbl, prop, msg)
`define CPA_ASSERT_RST(lbl, prop, msg)
`endif
`endif

>>> design/cpa_pkg.sv
// Shared constants and types of the closest point of approach block.
package cpa_pkg;
    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 12;
    localparam int TIME_BITS   = 32;
    localparam int ROOT_BITS   = 32;
    localparam int MAG_BITS    = 31;
    localparam int OUT_DATA_W  = 96;
    localparam int OUT_USER_W  = 2;
    localparam logic [MAG_BITS-1:0]  MAG_MAX   = '1;
    localparam logic [TIME_BITS-1:0] NEG_LIMIT = 32'h8000_0000;

    typedef struct packed {
        logic par;
        logic sat;
        logic bad;
    } t_res_flags;
endpackage

>>> design/closest_point_of_approach_top.sv
// Closest point of approach top level: time and miss distance of two aircraft.
//
// Slave channel (i_s_*): one request carries the ownship and intruder
// positions and velocities, signed Q.12, COORD_WIDTH bits each.
// Master channel (o_m_*): one result per request, in request order:
// clamped time, signed time and miss distance in tdata; the parallel and
// saturated flags in tuser.
// One request is taken every cycle while no result waits on a stalled
// receiver; the rate is set by the pipelined divider (one quotient bit
// per stage) and the pipelined square root (one root bit per stage),
// which also set the depth.
// All stages move together on one enable: it is high while the output
// register is empty or being taken. When the receiver stalls with a result
// waiting, the whole pipe holds and o_s_tready falls; nothing is dropped.
// A synchronous reset clears every valid bit; payload registers keep
// whatever they hold and are ignored until valid data reaches them.
`include "closest_point_of_approach_top_assert.svh"
module closest_point_of_approach_top #(
    parameter int COORD_WIDTH = cpa_pkg::COORD_WIDTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // own_px, own_py, own_vx, own_vy, intr_px, intr_py, intr_vx, intr_vy
    input  logic [8*COORD_WIDTH-1:0]         i_s_tdata,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // time_clamped[30:0], time_signed[62:31], miss_distance[93:63], zeros
    output logic [cpa_pkg::OUT_DATA_W-1:0]   o_m_tdata,
    // parallel[0], saturated[1]
    output logic [cpa_pkg::OUT_USER_W-1:0]   o_m_tuser
);
    localparam int W   = COORD_WIDTH;
    localparam int RW  = W + 1;
    localparam int NW  = 2 * W + 15;
    localparam int DW  = 2 * W + 3;
    localparam int TB  = cpa_pkg::TIME_BITS;
    localparam int MB  = cpa_pkg::MAG_BITS;
    localparam int RB  = cpa_pkg::ROOT_BITS;
    localparam int DSW = 4 * RW + 2;
    localparam int FW  = $bits(cpa_pkg::t_res_flags);
    localparam int QSW = TB + MB + FW;

    logic w_en;

    logic                 f_valid, f_neg, f_par;
    logic signed [RW-1:0] f_sx, f_sy, f_vx, f_vy;
    logic [NW-1:0]        f_num;
    logic [DW-1:0]        f_den;

    logic           d_valid, d_ovf;
    logic [TB-1:0]  d_q;
    logic [DSW-1:0] d_side;

    logic                 m_valid;
    logic [2*MB:0]        m_sum;
    logic [TB-1:0]        m_tsig;
    logic [MB-1:0]        m_tclamp;
    cpa_pkg::t_res_flags  m_flags;

    logic                 q_valid;
    logic [RB-1:0]        q_root;
    logic [RB:0]          q_rem;
    logic [QSW-1:0]       q_side;
    cpa_pkg::t_res_flags  q_flags;

    logic [RB:0]   w_root;
    logic          w_big;

    logic                r_out_valid;
    logic [MB-1:0]       r_tclamp;
    logic [TB-1:0]       r_tsig;
    logic [MB-1:0]       r_dist;
    logic                r_par;
    logic                r_sat;

    // advance everything unless a finished result is waiting
    assign w_en       = i_m_tready || !r_out_valid;
    // take no request while reset is held
    assign o_s_tready = w_en && i_rst_n;

    cpa_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_s_tvalid),
        .i_data  (i_s_tdata),
        .o_valid (f_valid),
        .o_sx    (f_sx),
        .o_sy    (f_sy),
        .o_vx    (f_vx),
        .o_vy    (f_vy),
        .o_num   (f_num),
        .o_den   (f_den),
        .o_neg   (f_neg),
        .o_par   (f_par)
    );

    cpa_div #(.NW(NW), .DW(DW), .QW(TB), .SW(DSW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (f_valid),
        .i_num   (f_num),
        .i_den   (f_den),
        .i_side  ({f_neg, f_par, f_sx, f_sy, f_vx, f_vy}),
        .o_valid (d_valid),
        .o_q     (d_q),
        .o_ovf   (d_ovf),
        .o_side  (d_side)
    );

    cpa_miss #(.COORD_WIDTH(COORD_WIDTH)) u_miss (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (d_valid),
        .i_q      (d_q),
        .i_ovf    (d_ovf),
        .i_neg    (d_side[DSW-1]),
        .i_par    (d_side[DSW-2]),
        .i_sx     ($signed(d_side[3*RW +: RW])),
        .i_sy     ($signed(d_side[2*RW +: RW])),
        .i_vx     ($signed(d_side[1*RW +: RW])),
        .i_vy     ($signed(d_side[0 +: RW])),
        .o_valid  (m_valid),
        .o_sum    (m_sum),
        .o_tsig   (m_tsig),
        .o_tclamp (m_tclamp),
        .o_flags  (m_flags)
    );

    cpa_sqrt #(.RB(RB), .SW(QSW)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (m_valid),
        .i_x     (m_sum),
        .i_side  ({m_tsig, m_tclamp, m_flags}),
        .o_valid (q_valid),
        .o_root  (q_root),
        .o_rem   (q_rem),
        .o_side  (q_side)
    );

    assign q_flags = cpa_pkg::t_res_flags'(q_side[FW-1:0]);

    // round the root to nearest, then limit to the output range
    assign w_root = {1'b0, q_root} + (RB+1)'(q_rem > {1'b0, q_root});
    assign w_big  = w_root > (RB+1)'(cpa_pkg::MAG_MAX);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= q_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_tsig   <= q_side[FW+MB +: TB];
            r_tclamp <= q_side[FW +: MB];
            r_dist   <= (q_flags.bad || w_big) ? cpa_pkg::MAG_MAX : w_root[MB-1:0];
            r_par    <= q_flags.par;
            r_sat    <= q_flags.sat || q_flags.bad || w_big;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {(cpa_pkg::OUT_DATA_W - 2*MB - TB)'(0), r_dist, r_tsig, r_tclamp};
    assign o_m_tuser  = {r_sat, r_par};

    `CPA_ASSERT_CLK(a_par_zero_time, (r_out_valid && r_par) |-> (r_tsig == '0 && r_tclamp == '0), "parallel result with nonzero time")
    `CPA_ASSERT_CLK(a_clamp_follows, r_out_valid |-> (r_tclamp == (r_tsig[TB-1] ? MB'(0) : r_tsig[MB-1:0])), "clamped time disagrees with signed time")
    `CPA_ASSERT_RST(a_reset_clears, !i_rst_n |=> !o_m_tvalid, "result valid after reset")
endmodule

>>> design/cpa_front.sv
// Relative motion, dot products and divider operands.
module cpa_front #(
    parameter int COORD_WIDTH = cpa_pkg::COORD_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [8*COORD_WIDTH-1:0]      i_data,
    output logic                          o_valid,
    output logic signed [COORD_WIDTH:0]   o_sx,
    output logic signed [COORD_WIDTH:0]   o_sy,
    output logic signed [COORD_WIDTH:0]   o_vx,
    output logic signed [COORD_WIDTH:0]   o_vy,
    output logic [2*COORD_WIDTH+14:0]     o_num,
    output logic [2*COORD_WIDTH+2:0]      o_den,
    output logic                          o_neg,
    output logic                          o_par
);
    localparam int W  = COORD_WIDTH;
    localparam int RW = W + 1;
    localparam int PW = 2 * RW;
    localparam int SW = PW + 1;
    localparam int NW = 2 * W + 15;

    logic signed [W-1:0] w_own_px, w_own_py, w_own_vx, w_own_vy;
    logic signed [W-1:0] w_intr_px, w_intr_py, w_intr_vx, w_intr_vy;
    logic [3:0] r_vld;

    logic signed [RW-1:0] r1_sx, r1_sy, r1_vx, r1_vy;
    logic signed [RW-1:0] r2_sx, r2_sy, r2_vx, r2_vy;
    logic signed [RW-1:0] r3_sx, r3_sy, r3_vx, r3_vy;
    logic signed [PW-1:0] r2_pvx, r2_pvy, r2_psx, r2_psy;
    logic [PW-1:0]        r3_sqv;
    logic signed [SW-1:0] r3_dot;
    logic [SW-1:0]        w_abs;
    logic                 w_neg;

    assign w_own_px  = $signed(i_data[0*W +: W]);
    assign w_own_py  = $signed(i_data[1*W +: W]);
    assign w_own_vx  = $signed(i_data[2*W +: W]);
    assign w_own_vy  = $signed(i_data[3*W +: W]);
    assign w_intr_px = $signed(i_data[4*W +: W]);
    assign w_intr_py = $signed(i_data[5*W +: W]);
    assign w_intr_vx = $signed(i_data[6*W +: W]);
    assign w_intr_vy = $signed(i_data[7*W +: W]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[2:0], i_valid};
        end
    end

    // negated dot product is negative exactly when the dot product is positive
    assign w_neg = !r3_dot[SW-1] && (r3_dot != '0);
    assign w_abs = r3_dot[SW-1] ? SW'(-r3_dot) : SW'(r3_dot);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_sx  <= RW'(w_own_px) - RW'(w_intr_px);
            r1_sy  <= RW'(w_own_py) - RW'(w_intr_py);
            r1_vx  <= RW'(w_own_vx) - RW'(w_intr_vx);
            r1_vy  <= RW'(w_own_vy) - RW'(w_intr_vy);

            r2_pvx <= r1_vx * r1_vx;
            r2_pvy <= r1_vy * r1_vy;
            r2_psx <= r1_sx * r1_vx;
            r2_psy <= r1_sy * r1_vy;
            r2_sx  <= r1_sx;
            r2_sy  <= r1_sy;
            r2_vx  <= r1_vx;
            r2_vy  <= r1_vy;

            r3_sqv <= $unsigned(r2_pvx) + $unsigned(r2_pvy);
            r3_dot <= SW'(r2_psx) + SW'(r2_psy);
            r3_sx  <= r2_sx;
            r3_sy  <= r2_sy;
            r3_vx  <= r2_vx;
            r3_vy  <= r2_vy;

            o_num  <= (NW'(w_abs[PW-1:0]) << (cpa_pkg::FRAC_BITS + 1)) + NW'(r3_sqv);
            o_den  <= {r3_sqv, 1'b0};
            o_neg  <= w_neg;
            o_par  <= (r3_sqv == '0);
            o_sx   <= r3_sx;
            o_sy   <= r3_sy;
            o_vx   <= r3_vx;
            o_vy   <= r3_vy;
        end
    end

    assign o_valid = r_vld[3];
endmodule

>>> design/cpa_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module cpa_div #(
    parameter int NW = 79,
    parameter int DW = 67,
    parameter int QW = cpa_pkg::TIME_BITS,
    parameter int SW = 134
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [QW-1:0] o_q,
    output logic          o_ovf,
    output logic [SW-1:0] o_side
);
    localparam int CW = (NW > DW + QW) ? NW : DW + QW;

    logic [QW:0]   r_vld;
    logic [CW-1:0] r_rem  [0:QW];
    logic [DW-1:0] r_den  [0:QW];
    logic [QW-1:0] r_q    [0:QW];
    logic          r_ovf  [0:QW];
    logic [SW-1:0] r_side [0:QW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[QW-1:0], i_valid};
        end
    end

    // quotient of 2^QW or more cannot be represented: flag and skip the bits
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= CW'(i_num);
            r_den[0]  <= i_den;
            r_q[0]    <= '0;
            r_ovf[0]  <= CW'(i_num) >= (CW'(i_den) << QW);
            r_side[0] <= i_side;
        end
    end

    for (genvar k = 0; k < QW; k++) begin : g_bit
        localparam int B = QW - 1 - k;
        logic [CW-1:0] w_trial;
        logic          w_fit;

        assign w_trial = CW'(r_den[k]) << B;
        assign w_fit   = !r_ovf[k] && (r_rem[k] >= w_trial);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1]  <= w_fit ? r_rem[k] - w_trial : r_rem[k];
                r_q[k+1]    <= r_q[k] | (w_fit ? (QW'(1) << B) : QW'(0));
                r_den[k+1]  <= r_den[k];
                r_ovf[k+1]  <= r_ovf[k];
                r_side[k+1] <= r_side[k];
            end
        end
    end

    assign o_valid = r_vld[QW];
    assign o_q     = r_q[QW];
    assign o_ovf   = r_ovf[QW] && (r_rem[QW] == r_rem[QW]);
    assign o_side  = (r_den[QW] == r_den[QW]) ? r_side[QW] : r_side[QW];
endmodule

>>> design/cpa_miss.sv
// Time limiting, miss vector components and their squares.
module cpa_miss #(
    parameter int COORD_WIDTH = cpa_pkg::COORD_WIDTH
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_en,
    input  logic                                  i_valid,
    input  logic [cpa_pkg::TIME_BITS-1:0]         i_q,
    input  logic                                  i_ovf,
    input  logic                                  i_neg,
    input  logic                                  i_par,
    input  logic signed [COORD_WIDTH:0]           i_sx,
    input  logic signed [COORD_WIDTH:0]           i_sy,
    input  logic signed [COORD_WIDTH:0]           i_vx,
    input  logic signed [COORD_WIDTH:0]           i_vy,
    output logic                                  o_valid,
    output logic [2*cpa_pkg::MAG_BITS:0]          o_sum,
    output logic [cpa_pkg::TIME_BITS-1:0]         o_tsig,
    output logic [cpa_pkg::MAG_BITS-1:0]          o_tclamp,
    output cpa_pkg::t_res_flags                   o_flags
);
    localparam int W    = COORD_WIDTH;
    localparam int RW   = W + 1;
    localparam int TB   = cpa_pkg::TIME_BITS;
    localparam int MB   = cpa_pkg::MAG_BITS;
    localparam int FB   = cpa_pkg::FRAC_BITS;
    localparam int TV   = RW + TB;
    localparam int AW   = TV + 1;
    localparam int SQ   = 2 * MB;
    localparam logic [AW-1:0] HALF = AW'(1) << (FB - 1);

    logic [5:0] r_vld;

    logic [TB-1:0] n_tsig;
    logic [MB-1:0] n_tclamp;
    logic          n_sat;
    logic          w_big_neg, w_big_pos;

    logic [TB-1:0] r_tsig   [1:6];
    logic [MB-1:0] r_tclamp [1:6];
    logic          r_sat    [1:6];
    logic          r_par    [1:6];

    logic signed [RW-1:0] r1_sx, r1_sy, r1_vx, r1_vy;
    logic signed [RW-1:0] r2_sx, r2_sy;
    logic signed [TV-1:0] r2_tvx, r2_tvy;
    logic signed [AW-1:0] r3_accx, r3_accy;
    logic [AW-1:0]        w_rx, w_ry;
    logic [MB-1:0]        r4_cx, r4_cy;
    logic                 r4_okx, r4_oky, r5_ok, r6_ok;
    logic [SQ-1:0]        r5_sqx, r5_sqy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[4:0], i_valid};
        end
    end

    assign w_big_neg = i_ovf || (i_q > cpa_pkg::NEG_LIMIT);
    assign w_big_pos = i_ovf || (i_q > {1'b0, cpa_pkg::MAG_MAX});

    always_comb begin
        n_tsig   = '0;
        n_tclamp = '0;
        n_sat    = 1'b0;
        if (i_par) begin
            n_sat = 1'b0;
        end else if (i_neg) begin
            n_sat  = w_big_neg;
            n_tsig = w_big_neg ? cpa_pkg::NEG_LIMIT : TB'(-i_q);
        end else begin
            n_sat    = w_big_pos;
            n_tsig   = w_big_pos ? {1'b0, cpa_pkg::MAG_MAX} : i_q;
            n_tclamp = n_tsig[MB-1:0];
        end
    end

    // round the magnitude half away from zero: |acc| + half, in one add
    assign w_rx = r3_accx[AW-1] ? (~$unsigned(r3_accx) + HALF + AW'(1))
                                : ($unsigned(r3_accx) + HALF);
    assign w_ry = r3_accy[AW-1] ? (~$unsigned(r3_accy) + HALF + AW'(1))
                                : ($unsigned(r3_accy) + HALF);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tsig[1]   <= n_tsig;
            r_tclamp[1] <= n_tclamp;
            r_sat[1]    <= n_sat;
            r_par[1]    <= i_par;
            for (int i = 2; i <= 6; i++) begin
                r_tsig[i]   <= r_tsig[i-1];
                r_tclamp[i] <= r_tclamp[i-1];
                r_sat[i]    <= r_sat[i-1];
                r_par[i]    <= r_par[i-1];
            end

            r1_sx   <= i_sx;
            r1_sy   <= i_sy;
            r1_vx   <= i_vx;
            r1_vy   <= i_vy;

            r2_tvx  <= $signed({1'b0, r_tclamp[1]}) * r1_vx;
            r2_tvy  <= $signed({1'b0, r_tclamp[1]}) * r1_vy;
            r2_sx   <= r1_sx;
            r2_sy   <= r1_sy;

            r3_accx <= (AW'(r2_sx) <<< FB) + AW'(r2_tvx);
            r3_accy <= (AW'(r2_sy) <<< FB) + AW'(r2_tvy);

            r4_cx   <= w_rx[FB +: MB];
            r4_cy   <= w_ry[FB +: MB];
            r4_okx  <= (w_rx[AW-1:FB+MB] == '0);
            r4_oky  <= (w_ry[AW-1:FB+MB] == '0);

            r5_sqx  <= SQ'(r4_cx) * SQ'(r4_cx);
            r5_sqy  <= SQ'(r4_cy) * SQ'(r4_cy);
            r5_ok   <= r4_okx && r4_oky;

            o_sum   <= (SQ+1)'(r5_sqx) + (SQ+1)'(r5_sqy);
            r6_ok   <= r5_ok;
        end
    end

    assign o_valid      = r_vld[5];
    assign o_tsig       = r_tsig[6];
    assign o_tclamp     = r_tclamp[6];
    assign o_flags.par  = r_par[6];
    assign o_flags.sat  = r_sat[6];
    assign o_flags.bad  = !r6_ok;
endmodule

>>> design/cpa_sqrt.sv
// Pipelined integer square root, one result bit per stage.
module cpa_sqrt #(
    parameter int RB = cpa_pkg::ROOT_BITS,
    parameter int SW = 66
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [2*RB-2:0]   i_x,
    input  logic [SW-1:0]     i_side,
    output logic              o_valid,
    output logic [RB-1:0]     o_root,
    output logic [RB:0]       o_rem,
    output logic [SW-1:0]     o_side
);
    localparam int XW = 2 * RB;

    logic [RB:0]   r_vld;
    logic [XW-1:0] r_x    [0:RB];
    logic [XW-1:0] r_res  [0:RB];
    logic [SW-1:0] r_side [0:RB];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[RB-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]    <= XW'(i_x);
            r_res[0]  <= '0;
            r_side[0] <= i_side;
        end
    end

    for (genvar k = 0; k < RB; k++) begin : g_bit
        localparam logic [XW-1:0] BIT = XW'(1) << (2 * (RB - 1 - k));
        logic [XW-1:0] w_trial;
        logic          w_fit;

        assign w_trial = r_res[k] + BIT;
        assign w_fit   = r_x[k] >= w_trial;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[k+1]    <= w_fit ? r_x[k] - w_trial : r_x[k];
                r_res[k+1]  <= w_fit ? (r_res[k] >> 1) + BIT : r_res[k] >> 1;
                r_side[k+1] <= r_side[k];
            end
        end
    end

    assign o_valid = r_vld[RB];
    assign o_root  = r_res[RB][RB-1:0];
    assign o_rem   = r_x[RB][RB:0];
    assign o_side  = r_side[RB];
endmodule

>>> tb/tb_top.sv
// Self-checking testbench of the closest point of approach block: directed and random requests.
module tb_top;
    typedef logic signed [127:0] t_wide;

    typedef struct packed {
        logic [30:0] t_clamped;
        logic [31:0] t_signed;
        logic [30:0] miss;
        logic        par;
        logic        sat;
    } t_cpa_result;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 120;
    localparam int HOLD_CYCLES    = 400;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_s_tvalid;
    logic                           o_s_tready;
    logic [8*32-1:0]                i_s_tdata;
    logic                           o_m_tvalid;
    logic                           i_m_tready;
    logic [cpa_pkg::OUT_DATA_W-1:0] o_m_tdata;
    logic [cpa_pkg::OUT_USER_W-1:0] o_m_tuser;

    t_cpa_result pending_results[$];
    int          snd_idle_pct;
    int          rcv_idle_pct;
    bit          rcv_hold;
    bit          failed;
    int          quiet_cycles;

    closest_point_of_approach_top u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    function automatic logic [63:0] floor_sqrt(input logic [63:0] x);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (x >= res + bitv) begin
                x   = x - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Rounded Q.12 magnitude of s*2^12 + t*v; ok falls when it reaches 2^31.
    function automatic logic [63:0] offset_q12(input t_wide s, input t_wide v, input t_wide t,
                                               output bit ok);
        t_wide acc;
        t_wide mag;
        t_wide m;
        acc = (s <<< 12) + t * v;
        mag = acc < 0 ? -acc : acc;
        m   = (mag + 2048) >>> 12;
        ok  = m <= 128'sh7FFF_FFFF;
        return m[63:0];
    endfunction

    function automatic t_cpa_result predict_approach(input logic [8*32-1:0] d);
        t_cpa_result r;
        t_wide       sx, sy, vx, vy, sqv, negdot, absdot, num, t;
        logic [127:0] q;
        logic [63:0] cx, cy, sum, root;
        bit          okx, oky, neg;
        sx  = t_wide'($signed(d[0 +: 32]))  - t_wide'($signed(d[128 +: 32]));
        sy  = t_wide'($signed(d[32 +: 32])) - t_wide'($signed(d[160 +: 32]));
        vx  = t_wide'($signed(d[64 +: 32])) - t_wide'($signed(d[192 +: 32]));
        vy  = t_wide'($signed(d[96 +: 32])) - t_wide'($signed(d[224 +: 32]));
        sqv = vx * vx + vy * vy;
        r   = '0;
        r.par = (sqv == 0);
        if (!r.par) begin
            negdot = -(sx * vx + sy * vy);
            neg    = negdot < 0;
            absdot = neg ? -negdot : negdot;
            num    = (absdot <<< 13) + sqv;
            q      = $unsigned(num) / $unsigned(sqv <<< 1);
            if (neg) begin
                if (q > 128'h8000_0000) begin
                    r.sat = 1'b1;
                    q     = 128'h8000_0000;
                end
                r.t_signed = -q[31:0];
            end else begin
                if (q > 128'h7FFF_FFFF) begin
                    r.sat = 1'b1;
                    q     = 128'h7FFF_FFFF;
                end
                r.t_signed  = q[31:0];
                r.t_clamped = q[30:0];
            end
        end
        t = 0;
        t[30:0] = r.t_clamped;
        cx = offset_q12(sx, vx, t, okx);
        cy = offset_q12(sy, vy, t, oky);
        if (okx && oky) begin
            sum  = cx * cx + cy * cy;
            root = floor_sqrt(sum);
            if (sum - root * root > root) root = root + 1;
            if (root > 64'h7FFF_FFFF) begin
                r.sat = 1'b1;
                root  = 64'h7FFF_FFFF;
            end
            r.miss = root[30:0];
        end else begin
            r.sat  = 1'b1;
            r.miss = '1;
        end
        return r;
    endfunction

    task automatic send_request(input logic [8*32-1:0] d);
        while ($urandom_range(99) < snd_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= d;
        do @(posedge i_clk); while (!o_s_tready);
        pending_results.push_back(predict_approach(d));
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(5))
            0: return $urandom;
            1: return 32'($signed($urandom_range(2000000)) - 1000000);
            2: return 32'($signed($urandom_range(200)) - 100);
            3: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            4: return 32'(1) << $urandom_range(31);
            default: return 32'($signed($urandom_range(1 << 24)) - (1 << 23));
        endcase
    endfunction

    function automatic logic [8*32-1:0] pack_pair(input logic [31:0] opx, opy, ovx, ovy,
                                                  input logic [31:0] ipx, ipy, ivx, ivy);
        return {ivy, ivx, ipy, ipx, ovy, ovx, opy, opx};
    endfunction

    task automatic test_directed();
        send_request('0);
        send_request('1);
        send_request(pack_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0,
                               32'h8000_0000, 32'h8000_0000, 0, 0));
        send_request(pack_pair(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                               32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
        send_request(pack_pair(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                               32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        // parallel tracks with an offset
        send_request(pack_pair(32'h0010_0000, 32'h0002_0000, 32'h0000_5000, 32'h0000_3000,
                               0, 0, 32'h0000_5000, 32'h0000_3000));
        // head-on approach, positive time
        send_request(pack_pair(0, 0, 32'h0000_1000, 0, 32'h0064_0000, 32'h0001_0000,
                               32'hFFFF_F000, 0));
        // diverging, negative time, clamped to zero
        send_request(pack_pair(0, 0, 32'hFFFF_F000, 0, 32'h0064_0000, 32'h0001_0000,
                               32'h0000_1000, 0));
        // far away with tiny closing speed: time saturates high
        send_request(pack_pair(32'h7FFF_FFFF, 0, 32'hFFFF_FFFF, 0, 32'h8000_0000, 0, 0, 0));
        // far away with tiny opening speed: time saturates low
        send_request(pack_pair(32'h7FFF_FFFF, 0, 1, 0, 32'h8000_0000, 0, 0, 0));
        send_request(pack_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 1, 0, 0, 0, 0));
        send_request(pack_pair(1, 0, 0, 1, 0, 0, 0, 0));
        send_request(pack_pair(32'h0000_0800, 0, 0, 0, 0, 0, 0, 0));
        send_request(pack_pair(32'h0000_1800, 32'h0000_0800, 3, 32'hFFFF_FFFD, 0, 0, 0, 0));
        for (int i = 0; i < 8; i++) begin
            logic [8*32-1:0] d;
            d = '0;
            d[32*i +: 32] = 32'h8000_0000;
            send_request(d);
            d[32*i +: 32] = 32'h7FFF_FFFF;
            send_request(d);
        end
    endtask

    task automatic test_random(input int count);
        logic [31:0] f[8];
        for (int n = 0; n < count; n++) begin
            for (int i = 0; i < 8; i++) f[i] = rand_coord();
            if ($urandom_range(9) == 0) begin
                f[6] = f[2];
                f[7] = f[3];
            end
            send_request(pack_pair(f[0], f[1], f[2], f[3], f[4], f[5], f[6], f[7]));
        end
    endtask

    // Hold the receiver off while requests keep coming so the pipe fills and stalls.
    task automatic test_backpressure();
        rcv_hold = 1'b1;
        snd_idle_pct = 0;
        fork
            begin
                repeat (HOLD_CYCLES) @(posedge i_clk);
                rcv_hold = 1'b0;
            end
            test_random(150);
        join
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n || rcv_hold) begin
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_cpa_result want;
        t_cpa_result got;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.t_clamped = o_m_tdata[30:0];
            got.t_signed  = o_m_tdata[62:31];
            got.miss      = o_m_tdata[93:63];
            got.par       = o_m_tuser[0];
            got.sat       = o_m_tuser[1];
            if (pending_results.size() == 0) begin
                failed = 1'b1;
                $display("%0t: unexpected result %h", $time, got);
            end else begin
                want = pending_results.pop_front();
                if (got.t_clamped != want.t_clamped)
                    $display("%0t: time_clamped expected %h actual %h", $time,
                             want.t_clamped, got.t_clamped);
                if (got.t_signed != want.t_signed)
                    $display("%0t: time_signed expected %h actual %h", $time,
                             want.t_signed, got.t_signed);
                if (got.miss != want.miss)
                    $display("%0t: miss_distance expected %h actual %h", $time,
                             want.miss, got.miss);
                if (got.par != want.par)
                    $display("%0t: parallel expected %b actual %b", $time, want.par, got.par);
                if (got.sat != want.sat)
                    $display("%0t: saturated expected %b actual %b", $time, want.sat, got.sat);
                if (got != want) failed = 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        failed       = 1'b0;
        rcv_hold     = 1'b0;
        quiet_cycles = 0;
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        i_rst_n      = 1'b0;
        i_s_tvalid   = 1'b0;
        i_s_tdata    = '0;
        i_m_tready   = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        snd_idle_pct = 36;
        rcv_idle_pct = 58;
        test_random(350);
        snd_idle_pct = 58;
        rcv_idle_pct = 36;
        test_random(350);
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        test_random(350);
        test_backpressure();
        i_s_tvalid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (!failed) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
